// File: rtl/divisor_sum_count_engine_macros.svh
// Assertion macros shared by the divisor sum and count engine.
`ifndef DIVISOR_SUM_COUNT_ENGINE_MACROS_SVH
`define DIVISOR_SUM_COUNT_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dsc_pkg.sv
// Shared constants and the sequencer state type for the divisor sum and count engine.
package dsc_pkg;

  localparam int unsigned SUM_W   = 34;
  localparam int unsigned COUNT_W = 11;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_CHECK,
    S_ADD_D,
    S_ADD_CO,
    S_FINISH
  } dsc_state_t;

endpackage

// File: rtl/dsc_divider.sv
// Bit-serial restoring divider giving quotient and remainder, one bit per cycle.
module dsc_divider #(
  parameter int unsigned W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {remainder, quotient[W-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient register starts as the dividend and fills with result bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (run) begin
      if (!diff[W]) begin
        remainder <= diff[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b1};
      end else begin
        remainder <= shifted[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/divisor_sum_count_engine.sv
// Divisor sum and count engine: trial division over candidates 1 .. floor(sqrt(number)).
// Each candidate is divided by the bit-serial divider, which all candidates share.
// One beat is worked on at a time; a zero input skips the division and goes straight to
// the finish state with the error flag.
// Synchronous active-high reset returns the sequencer to idle and drops out_valid.
module divisor_sum_count_engine #(
  parameter int unsigned NUMBER_WIDTH = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [NUMBER_WIDTH-1:0]     number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dsc_pkg::SUM_W-1:0]   divisor_sum,
  output logic [dsc_pkg::COUNT_W-1:0] divisor_count,
  output logic                        is_deficient,
  output logic                        bad_input
);

  import dsc_pkg::*;

  localparam int unsigned EXT_W = ((NUMBER_WIDTH > SUM_W) ? NUMBER_WIDTH : SUM_W) + 1;

  dsc_state_t state, state_next;

  logic [NUMBER_WIDTH-1:0] held_number;
  logic [NUMBER_WIDTH-1:0] trial_divisor;
  logic [SUM_W-1:0]        running_sum;
  logic [COUNT_W-1:0]      running_count;
  logic [NUMBER_WIDTH:0]   proper_sum;
  logic                    bad_flag;

  logic                    div_start;
  logic                    div_done;
  logic [NUMBER_WIDTH-1:0] quotient;
  logic [NUMBER_WIDTH-1:0] remainder;

  logic [NUMBER_WIDTH-1:0] add_operand;
  logic [EXT_W-1:0]        sum_ext;
  logic [SUM_W-1:0]        sum_sat;
  logic                    proper_take;
  logic                    out_free;

  dsc_divider #(.W(NUMBER_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (held_number),
    .divisor   (trial_divisor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // In the cofactor step the quotient is added, otherwise the trial divisor itself.
  assign add_operand = (state == S_ADD_CO) ? quotient : trial_divisor;
  assign sum_ext     = EXT_W'(running_sum) + EXT_W'(add_operand);
  assign sum_sat     = (sum_ext >= EXT_W'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
  // The proper-divisor sum stops growing once it reaches the number.
  assign proper_take = (add_operand != held_number) &&
                       (proper_sum < {1'b0, held_number});
  assign out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (number == '0) ? S_FINISH : S_START;
        end
      end
      S_START: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (trial_divisor > quotient) begin
          state_next = S_FINISH;
        end else if (remainder == '0) begin
          state_next = S_ADD_D;
        end else begin
          state_next = S_START;
        end
      end
      S_ADD_D: begin
        state_next = (quotient != trial_divisor) ? S_ADD_CO : S_START;
      end
      S_ADD_CO: begin
        state_next = S_START;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_number   <= '0;
      trial_divisor <= '0;
      running_sum   <= '0;
      running_count <= '0;
      proper_sum    <= '0;
      bad_flag      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            held_number   <= number;
            trial_divisor <= NUMBER_WIDTH'(1);
            running_sum   <= '0;
            running_count <= '0;
            proper_sum    <= '0;
            bad_flag      <= (number == '0);
          end
        end
        S_CHECK: begin
          if (trial_divisor <= quotient && remainder != '0) begin
            trial_divisor <= trial_divisor + NUMBER_WIDTH'(1);
          end
        end
        S_ADD_D, S_ADD_CO: begin
          running_sum <= sum_sat;
          if (running_count != COUNT_MAX) begin
            running_count <= running_count + COUNT_W'(1);
          end
          if (proper_take) begin
            proper_sum <= proper_sum + {1'b0, add_operand};
          end
          if (state == S_ADD_CO || quotient == trial_divisor) begin
            trial_divisor <= trial_divisor + NUMBER_WIDTH'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      divisor_sum   <= running_sum;
      divisor_count <= running_count;
      is_deficient  <= !bad_flag && (proper_sum < {1'b0, held_number});
      bad_input     <= bad_flag;
    end
  end

`include "divisor_sum_count_engine_macros.svh"

  `DSC_ASSERT_NOW(a_bad_zero, out_valid && bad_input, divisor_sum == '0 && divisor_count == '0 && !is_deficient, "error beat carries non-zero results")
  `DSC_ASSERT_NOW(a_count_nonzero, out_valid && !bad_input, divisor_count != '0, "valid number reported with no divisors")
  `DSC_ASSERT_NOW(a_div_done_state, div_done, state == S_DIV, "divider finished outside its wait state")
  `DSC_ASSERT_NEXT(a_start_waits, state == S_START, state == S_DIV && !div_done, "sequencer did not wait for the divider")

endmodule

// File: tb/sv/tb_divisor_sum_count_engine.sv
// Testbench for the divisor sum and count engine: a directed table, then random numbers.
module tb_divisor_sum_count_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import dsc_pkg::*;

  localparam int unsigned NUM_W = 31;
  localparam int unsigned RANDOM_NUMBERS = 1280;
  localparam int unsigned CALM_TAIL = 150;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned ROWS = 22;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic               deficient;
    logic               bad;
  } divisor_result_t;

  typedef struct packed {
    logic [NUM_W-1:0] value;
    logic             typed_in;
    divisor_result_t  want;
  } directed_row_t;

  // Rows with typed_in set carry their result; the rest are worked out by the predictor.
  localparam directed_row_t DIRECTED [ROWS] = '{
    '{31'd0,          1'b1, '{34'd0,          11'd0, 1'b0, 1'b1}},
    '{31'd1,          1'b1, '{34'd1,          11'd1, 1'b1, 1'b0}},
    '{31'd2,          1'b1, '{34'd3,          11'd2, 1'b1, 1'b0}},
    '{31'd0,          1'b1, '{34'd0,          11'd0, 1'b0, 1'b1}},
    '{31'd3,          1'b0, '0},
    '{31'd4,          1'b0, '0},
    '{31'd6,          1'b0, '0},
    '{31'd12,         1'b0, '0},
    '{31'd28,         1'b0, '0},
    '{31'd36,         1'b0, '0},
    '{31'd97,         1'b0, '0},
    '{31'd255,        1'b0, '0},
    '{31'd256,        1'b0, '0},
    '{31'd496,        1'b0, '0},
    '{31'd945,        1'b0, '0},
    '{31'd8128,       1'b0, '0},
    '{31'd65535,      1'b0, '0},
    '{31'd720720,     1'b0, '0},
    '{31'd1048576,    1'b0, '0},
    '{31'd2147483647, 1'b1, '{34'd2147483648, 11'd2, 1'b1, 1'b0}},
    '{31'd0,          1'b1, '{34'd0,          11'd0, 1'b0, 1'b1}},
    '{31'd1,          1'b1, '{34'd1,          11'd1, 1'b1, 1'b0}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [NUM_W-1:0]   number = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SUM_W-1:0]   divisor_sum;
  logic [COUNT_W-1:0] divisor_count;
  logic               is_deficient;
  logic               bad_input;

  divisor_result_t pending_results [$];
  int unsigned     mismatches = 0;
  int unsigned     numbers_sent = 0;
  int unsigned     results_seen = 0;
  int unsigned     zero_seen = 0;
  int unsigned     deficient_seen = 0;
  int unsigned     abundant_seen = 0;
  bit              gaps_on = 1'b1;

  divisor_sum_count_engine #(
    .NUMBER_WIDTH(NUM_W)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .number       (number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .divisor_sum  (divisor_sum),
    .divisor_count(divisor_count),
    .is_deficient (is_deficient),
    .bad_input    (bad_input)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned add_capped(longint unsigned a, longint unsigned b,
                                                 longint unsigned cap);
    if (a >= cap || b >= cap - a) return cap;
    return a + b;
  endfunction

  // Divisors are found in pairs d and n/d up to the square root, as the hardware does.
  function automatic divisor_result_t predict_divisors(logic [NUM_W-1:0] value);
    longint unsigned n, d, co, total, tally, proper;
    divisor_result_t r;
    n = 64'(value);
    total = 0;
    tally = 0;
    proper = 0;
    r = '0;
    if (n == 0) begin
      r.bad = 1'b1;
      return r;
    end
    for (d = 1; d <= n / d; d++) begin
      if (n % d == 0) begin
        co = n / d;
        total = add_capped(total, d, 64'(SUM_MAX));
        tally = add_capped(tally, 1, 64'(COUNT_MAX));
        // The proper-divisor sum stops growing once it reaches the number.
        if (d != n && proper < n) proper += d;
        if (co != d) begin
          total = add_capped(total, co, 64'(SUM_MAX));
          tally = add_capped(tally, 1, 64'(COUNT_MAX));
          if (co != n && proper < n) proper += co;
        end
      end
    end
    r.sum = total[SUM_W-1:0];
    r.count = tally[COUNT_W-1:0];
    r.deficient = (proper < n);
    return r;
  endfunction

  // Mostly small numbers, since the work grows with the square root of the number.
  function automatic logic [NUM_W-1:0] pick_number();
    int unsigned roll, k;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 6) begin
      k = $urandom_range(2, 90);
      return NUM_W'(k * k);
    end
    if (roll < 8) begin
      unique case ($urandom_range(0, 3))
        0: return NUM_W'(6);
        1: return NUM_W'(28);
        2: return NUM_W'(496);
        default: return NUM_W'(8128);
      endcase
    end
    if (roll < 75) return NUM_W'($urandom_range(1, 255));
    if (roll < 97) return NUM_W'($urandom_range(256, 4095));
    return NUM_W'($urandom_range(4096, 65535));
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic send_number(input logic [NUM_W-1:0] value, input logic typed_in,
                             input divisor_result_t typed_want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    number <= value;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed_in ? typed_want : predict_divisors(value));
    numbers_sent++;
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 1) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    divisor_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 64'(divisor_sum), 0);
      end else begin
        want = pending_results.pop_front();
        if (divisor_sum !== want.sum)
          report_mismatch("divisor_sum", 64'(divisor_sum), 64'(want.sum));
        if (divisor_count !== want.count)
          report_mismatch("divisor_count", 64'(divisor_count), 64'(want.count));
        if (is_deficient !== want.deficient)
          report_mismatch("is_deficient", 64'(is_deficient), 64'(want.deficient));
        if (bad_input !== want.bad)
          report_mismatch("bad_input", 64'(bad_input), 64'(want.bad));
        results_seen++;
        if (want.bad) zero_seen++;
        else if (want.deficient) deficient_seen++;
        else abundant_seen++;
      end
    end
  end

  initial begin
    divisor_result_t none;
    none = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < ROWS; i++)
      send_number(DIRECTED[i].value, DIRECTED[i].typed_in, DIRECTED[i].want);
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      // The closing stretch runs with both sides always ready.
      if (i == RANDOM_NUMBERS - CALM_TAIL) gaps_on = 1'b0;
      send_number(pick_number(), 1'b0, none);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d numbers sent, %0d results checked, %0d mismatches",
             numbers_sent, results_seen, mismatches);
    $display("summary: %0d zero inputs, %0d deficient, %0d perfect or abundant",
             zero_seen, deficient_seen, abundant_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/dsc_pkg.sv
rtl/dsc_divider.sv
rtl/divisor_sum_count_engine.sv
tb/sv/tb_divisor_sum_count_engine.sv
